// ===== hdl/pop3lc_pkg.sv =====
// ----------------------------------------------------------------------------
// pop3lc_pkg
// shared types, constants and lookup functions of the pop3 line classifier
// ----------------------------------------------------------------------------
package pop3lc_pkg;

   localparam int TEXT_BUF   = 128;
   localparam int VERB_BUF   = 8;
   localparam int TEXT_CAP   = ((TEXT_BUF - 1) < 127) ? (TEXT_BUF - 1) : 127;
   localparam int VERB_CAP   = ((VERB_BUF - 1) < 7) ? (VERB_BUF - 1) : 7;
   localparam int VERB_CMP   = 4;

   localparam logic [15:0] DEFAULT_PORT = 16'd110;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam logic [1:0] CONF_NONE     = 2'd0;
   localparam logic [1:0] CONF_POSSIBLE = 2'd1;
   localparam logic [1:0] CONF_LIKELY   = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_OK      = 2'd1;
   localparam logic [1:0] KIND_ERR     = 2'd2;
   localparam logic [1:0] KIND_COMMAND = 2'd3;

   localparam logic [3:0] CMD_USER  = 4'd0;
   localparam logic [3:0] CMD_PASS  = 4'd1;
   localparam logic [3:0] CMD_LIST  = 4'd2;
   localparam logic [3:0] CMD_RETR  = 4'd3;
   localparam logic [3:0] CMD_DELE  = 4'd4;
   localparam logic [3:0] CMD_TOP   = 4'd5;
   localparam logic [3:0] CMD_UIDL  = 4'd6;
   localparam logic [3:0] CMD_APOP  = 4'd7;
   localparam logic [3:0] CMD_OTHER = 4'd8;

   localparam logic [1:0] OK_LEN  = 2'd3;
   localparam logic [2:0] ERR_LEN = 3'd4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] dest_port;
      logic        is_tcp;
   } req_type;

   typedef struct packed {
      logic [1:0]  detect_confidence;
      logic [1:0]  record_kind;
      logic [3:0]  command_code;
      logic [2:0]  verb_length;
      logic        password_present;
      logic        text_present;
      logic [15:0] text_offset;
      logic [6:0]  text_length;
   } rsp_type;

   // per-packet summary handed from the byte tracker to the classifier
   typedef struct packed {
      logic [15:0]                  byte_count;
      logic [15:0]                  line_stop;
      logic                         line_ok;
      logic [1:0]                   ok_prog;
      logic [2:0]                   err_prog;
      logic [2:0]                   upper_run;
      logic                         upper_open;
      logic                         run_space;
      logic                         space_seen;
      logic [15:0]                  verb_stop_pos;
      logic [VERB_CMP-1:0][7:0]     verb_chars;
      logic [15:0]                  dest_port;
      logic                         is_tcp;
   } summary_type;

   function automatic logic [7:0] ok_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h2B;
         2'd1:    c = 8'h4F;
         2'd2:    c = 8'h4B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] err_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h2D;
         3'd1:    c = 8'h45;
         3'd2:    c = 8'h52;
         3'd3:    c = 8'h52;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // verb names, first character in the low byte
   function automatic logic [31:0] verb_name(input logic [2:0] k);
      logic [31:0] n;
      case (k)
         3'd0:    n = 32'h52455355;
         3'd1:    n = 32'h53534150;
         3'd2:    n = 32'h5453494C;
         3'd3:    n = 32'h52544552;
         3'd4:    n = 32'h454C4544;
         3'd5:    n = 32'h00504F54;
         3'd6:    n = 32'h4C444955;
         default: n = 32'h504F5041;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] verb_size(input logic [2:0] k);
      return (k == 3'd5) ? 3'd3 : 3'd4;
   endfunction

   function automatic logic [3:0] verb_lookup(input logic [2:0] vn,
                                             input logic [VERB_CMP-1:0][7:0] chars);
      logic [3:0]  code;
      logic        hit;
      logic [31:0] name;
      code = CMD_OTHER;
      for (int k = 7; k >= 0; k--) begin
         name = verb_name(3'(k));
         hit  = (vn == verb_size(3'(k)));
         for (int j = 0; j < VERB_CMP; j++) begin
            if ((3'(j) < verb_size(3'(k))) && (chars[j] != name[8*j +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = 4'(k);
         end
      end
      return code;
   endfunction

endpackage

// ===== hdl/pop3lc_line_track.sv =====
// ----------------------------------------------------------------------------
// pop3lc_line_track
// per-byte tracking of the first line, prefixes and verb; registers a summary
// of the packet when its last byte is taken
// ----------------------------------------------------------------------------
module pop3lc_line_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  pop3lc_pkg::req_type    byte_in,
   input  logic                   sum_take,
   output logic                   sum_valid,
   output pop3lc_pkg::summary_type sum_data
);

   typedef struct packed {
      logic [15:0] byte_count;
      logic        line_done;
      logic [15:0] line_stop_pos;
      logic        pending_cr;
      logic [15:0] cr_pos;
      logic        ok_before_cr;
      logic        crlf_ok;
      logic        lf_seen;
      logic [15:0] lf_pos;
      logic        lf_ok;
      logic        line_ok;
      logic [1:0]  ok_prog;
      logic [2:0]  err_prog;
      logic [2:0]  upper_run;
      logic        upper_open;
      logic        run_space;
      logic        space_seen;
      logic [15:0] verb_stop_pos;
   } track_type;

   localparam track_type TRACK_RESET = '{
      byte_count: 16'd0, line_done: 1'b0, line_stop_pos: 16'd0, pending_cr: 1'b0,
      cr_pos: 16'd0, ok_before_cr: 1'b0, crlf_ok: 1'b0, lf_seen: 1'b0,
      lf_pos: 16'd0, lf_ok: 1'b0, line_ok: 1'b1, ok_prog: 2'd0, err_prog: 3'd0,
      upper_run: 3'd0, upper_open: 1'b1, run_space: 1'b0, space_seen: 1'b0,
      verb_stop_pos: 16'd0
   };

   track_type                               trk_ff, trk_in;
   logic [pop3lc_pkg::VERB_CMP-1:0][7:0]    verb_ff, verb_in;
   logic                                    sum_valid_ff, sum_valid_in;
   pop3lc_pkg::summary_type                 sum_ff, sum_in;

   logic [15:0] pos;
   logic [7:0]  b;
   logic        printable;
   logic        upper;
   logic [7:0]  folded;

   always_comb begin
      pos       = trk_ff.byte_count;
      b         = byte_in.data_byte;
      printable = ((b >= pop3lc_pkg::CHAR_SPACE) && (b <= pop3lc_pkg::CHAR_TILDE))
                  || (b == pop3lc_pkg::CHAR_TAB);
      upper     = (b >= pop3lc_pkg::CHAR_UP_A) && (b <= pop3lc_pkg::CHAR_UP_Z);
      folded    = ((b >= pop3lc_pkg::CHAR_LO_A) && (b <= pop3lc_pkg::CHAR_LO_Z))
                  ? (b - pop3lc_pkg::CASE_BIT) : b;

      trk_in       = trk_ff;
      verb_in      = verb_ff;
      sum_in       = sum_ff;
      sum_valid_in = sum_valid_ff & ~sum_take;

      if (byte_valid) begin
         if (b == pop3lc_pkg::CHAR_LF) begin
            if (trk_ff.pending_cr && !trk_ff.line_done) begin
               trk_in.line_done     = 1'b1;
               trk_in.line_stop_pos = trk_ff.cr_pos;
               trk_in.crlf_ok       = trk_ff.ok_before_cr;
            end
            if (!trk_ff.lf_seen) begin
               trk_in.lf_seen = 1'b1;
               trk_in.lf_pos  = pos;
               trk_in.lf_ok   = trk_ff.line_ok;
            end
         end
         if (b == pop3lc_pkg::CHAR_CR) begin
            trk_in.cr_pos       = pos;
            trk_in.ok_before_cr = trk_ff.line_ok;
         end
         trk_in.pending_cr = (b == pop3lc_pkg::CHAR_CR);

         if ((trk_ff.ok_prog < pop3lc_pkg::OK_LEN) && (pos == 16'(trk_ff.ok_prog))
             && (b == pop3lc_pkg::ok_char(trk_ff.ok_prog))) begin
            trk_in.ok_prog = trk_ff.ok_prog + 2'd1;
         end
         if ((trk_ff.err_prog < pop3lc_pkg::ERR_LEN) && (pos == 16'(trk_ff.err_prog))
             && (b == pop3lc_pkg::err_char(trk_ff.err_prog))) begin
            trk_in.err_prog = trk_ff.err_prog + 3'd1;
         end

         if (trk_ff.upper_open) begin
            if (upper) begin
               if (trk_ff.upper_run < 3'd5) begin
                  trk_in.upper_run = trk_ff.upper_run + 3'd1;
               end
            end else begin
               trk_in.upper_open = 1'b0;
               trk_in.run_space  = (b == pop3lc_pkg::CHAR_SPACE);
            end
         end
         if ((b == pop3lc_pkg::CHAR_SPACE) && !trk_ff.space_seen) begin
            trk_in.space_seen    = 1'b1;
            trk_in.verb_stop_pos = pos;
         end
         // only the first few verb characters take part in the lookup
         if (pos < 16'(pop3lc_pkg::VERB_CMP)) begin
            verb_in[pos[$clog2(pop3lc_pkg::VERB_CMP)-1:0]] = folded;
         end

         trk_in.line_ok = trk_ff.line_ok & printable;
         if (pos != pop3lc_pkg::POS_MAX) begin
            trk_in.byte_count = pos + 16'd1;
         end

         if (byte_in.last_byte) begin
            if (trk_in.line_done) begin
               sum_in.line_stop = trk_in.line_stop_pos;
               sum_in.line_ok   = trk_in.crlf_ok;
            end else if (trk_in.lf_seen) begin
               sum_in.line_stop = trk_in.lf_pos;
               sum_in.line_ok   = trk_in.lf_ok;
            end else begin
               sum_in.line_stop = trk_in.byte_count;
               sum_in.line_ok   = trk_in.line_ok;
            end
            sum_in.byte_count    = trk_in.byte_count;
            sum_in.ok_prog       = trk_in.ok_prog;
            sum_in.err_prog      = trk_in.err_prog;
            sum_in.upper_run     = trk_in.upper_run;
            sum_in.upper_open    = trk_in.upper_open;
            sum_in.run_space     = trk_in.run_space;
            sum_in.space_seen    = trk_in.space_seen;
            sum_in.verb_stop_pos = trk_in.verb_stop_pos;
            sum_in.verb_chars    = verb_in;
            sum_in.dest_port     = byte_in.dest_port;
            sum_in.is_tcp        = byte_in.is_tcp;
            sum_valid_in         = 1'b1;
            trk_in               = TRACK_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_ff       <= TRACK_RESET;
         sum_valid_ff <= 1'b0;
      end else begin
         trk_ff       <= trk_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verb_ff <= verb_in;
      sum_ff  <= sum_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum_data  = sum_ff;

endmodule

// ===== hdl/pop3lc_classify.sv =====
// ----------------------------------------------------------------------------
// pop3lc_classify
// turns a packet summary into the detection result and holds it in the
// output register
// ----------------------------------------------------------------------------
module pop3lc_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sum_valid,
   input  pop3lc_pkg::summary_type sum_data,
   input  logic [15:0]             server_port,
   output logic                    sum_take,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pop3lc_pkg::rsp_type     rsp_data
);

   logic                rsp_valid_ff, rsp_valid_in;
   pop3lc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        rsp_free;
   logic        port_hit;
   logic        is_ok;
   logic        is_err;
   logic        is_cmd;
   logic [15:0] verb_stop;
   logic [2:0]  vn;
   logic [3:0]  code;
   logic [15:0] arg_first;
   logic [15:0] arg_len;
   logic [15:0] err_len;

   assign rsp_free = ~rsp_valid_ff | rsp_ready;
   assign sum_take = sum_valid & rsp_free;

   always_comb begin
      port_hit = (sum_data.dest_port == server_port);
      is_ok    = (sum_data.line_stop >= 16'd3) && (sum_data.ok_prog == pop3lc_pkg::OK_LEN);
      is_err   = (sum_data.line_stop >= 16'd4) && (sum_data.err_prog == pop3lc_pkg::ERR_LEN);
      is_cmd   = ((sum_data.upper_run == 3'd3) || (sum_data.upper_run == 3'd4))
                 && ((16'(sum_data.upper_run) == sum_data.line_stop)
                     || (!sum_data.upper_open && sum_data.run_space));

      verb_stop = (sum_data.space_seen && (sum_data.verb_stop_pos < sum_data.line_stop))
                  ? sum_data.verb_stop_pos : sum_data.line_stop;
      vn        = (verb_stop < 16'(pop3lc_pkg::VERB_CAP))
                  ? verb_stop[2:0] : 3'(pop3lc_pkg::VERB_CAP);
      code      = pop3lc_pkg::verb_lookup(vn, sum_data.verb_chars);
      arg_first = (verb_stop < sum_data.line_stop) ? (verb_stop + 16'd1) : sum_data.line_stop;
      arg_len   = sum_data.line_stop - arg_first;
      err_len   = sum_data.line_stop - 16'd5;

      rsp_data_in = '0;
      if (sum_data.is_tcp && (sum_data.byte_count >= 16'd3) && sum_data.line_ok
          && (is_ok || is_err || is_cmd)) begin
         rsp_data_in.detect_confidence = port_hit ? pop3lc_pkg::CONF_LIKELY
                                                  : pop3lc_pkg::CONF_POSSIBLE;
      end

      if (sum_data.line_ok) begin
         if (!port_hit) begin
            if (is_ok) begin
               rsp_data_in.record_kind = pop3lc_pkg::KIND_OK;
            end else if (is_err) begin
               rsp_data_in.record_kind = pop3lc_pkg::KIND_ERR;
               if (sum_data.line_stop > 16'd5) begin
                  rsp_data_in.text_present = 1'b1;
                  rsp_data_in.text_offset  = 16'd5;
                  rsp_data_in.text_length  = (err_len < 16'(pop3lc_pkg::TEXT_CAP))
                                             ? err_len[6:0] : 7'(pop3lc_pkg::TEXT_CAP);
               end
            end
         end else begin
            rsp_data_in.record_kind  = pop3lc_pkg::KIND_COMMAND;
            rsp_data_in.command_code = code;
            rsp_data_in.verb_length  = vn;
            if (code == pop3lc_pkg::CMD_PASS) begin
               rsp_data_in.password_present = 1'b1;
            end else if ((code != pop3lc_pkg::CMD_OTHER) && (arg_len != 16'd0)) begin
               rsp_data_in.text_present = 1'b1;
               rsp_data_in.text_offset  = arg_first;
               rsp_data_in.text_length  = (arg_len < 16'(pop3lc_pkg::TEXT_CAP))
                                          ? arg_len[6:0] : 7'(pop3lc_pkg::TEXT_CAP);
            end
         end
      end

      rsp_valid_in = sum_take | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/pop3_line_classifier.sv =====
// ----------------------------------------------------------------------------
// pop3_line_classifier
// classifies the first line of a tcp payload as a pop3 status or command
//
// request channel (req_*): one payload byte per request with a last-byte
// mark; dest_port and is_tcp are taken from the last byte. a request is taken
// in every cycle while req_ready is high, so one byte per clock is sustained.
// response channel (rsp_*): one response per packet. the byte tracker closes
// the packet into a summary register at the edge that takes the last byte,
// and the classifier's decode of the summary loads the response register
// once that register is free; rsp_valid is driven from the response register.
// csr port: csr_wr_en writes csr_wr_data into server_port at once; write it
// only while no packet is in flight.
// reset clears the packet state and sets server_port to 110.
// when rsp_ready is low the response waits in its register and the summary
// register still takes one more packet; req_ready drops only when both hold
// a packet, and bytes that do not end a packet are then held off as well.
// ----------------------------------------------------------------------------
module pop3_line_classifier (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pop3lc_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pop3lc_pkg::rsp_type  rsp_data,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);

   logic [15:0]             server_port_ff, server_port_in;
   logic                    sum_valid;
   logic                    sum_take;
   pop3lc_pkg::summary_type sum_data;
   logic                    req_take;

   assign server_port_in = csr_wr_en ? csr_wr_data : server_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_port_ff <= pop3lc_pkg::DEFAULT_PORT;
      end else begin
         server_port_ff <= server_port_in;
      end
   end

   assign req_ready = ~sum_valid | sum_take;
   assign req_take  = req_valid & req_ready;

   pop3lc_line_track u_track (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_take),
      .byte_in    (req_data),
      .sum_take   (sum_take),
      .sum_valid  (sum_valid),
      .sum_data   (sum_data)
   );

   pop3lc_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .sum_valid   (sum_valid),
      .sum_data    (sum_data),
      .server_port (server_port_ff),
      .sum_take    (sum_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
